FILE: hdl/plist_pkg.sv
`timescale 1ns / 1ps

package plist_pkg;

    localparam int CAPACITY = 256;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;
    localparam int FUNC_W   = 3;
    localparam int LEN_W    = 9;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 16;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [FUNC_W-1:0] {
        FN_GET    = 3'd0,
        FN_INSERT = 3'd1,
        FN_DELETE = 3'd2,
        FN_CLEAR  = 3'd3,
        FN_LENGTH = 3'd4
    } func_t;

    // Command broadcast to every cell of the list.
    typedef struct packed {
        logic              en;
        logic              ins;
        logic              del;
        logic              rd;
        logic [POS_W-1:0]  pos_idx;
        logic [DATA_W-1:0] value;
    } plist_cmd_t;

endpackage

FILE: hdl/plist_if.sv
`timescale 1ns / 1ps

interface plist_req_if;
    logic                           valid;
    logic                           ready;
    logic [plist_pkg::FUNC_W-1:0]   func;
    logic [plist_pkg::POS_W-1:0]    position;
    logic signed [plist_pkg::DATA_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface plist_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic signed [plist_pkg::DATA_W-1:0] read_value;
    logic [plist_pkg::LEN_W-1:0]    length;

    modport source (output valid, output status, output read_value, output length, input ready);
    modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

FILE: hdl/plist_cell.sv
`timescale 1ns / 1ps

module plist_cell (
    input  logic                            clk,
    input  plist_pkg::plist_cmd_t           cmd,
    input  logic [plist_pkg::POS_W-1:0]     idx,
    input  logic [plist_pkg::DATA_W-1:0]    left_data,
    input  logic [plist_pkg::DATA_W-1:0]    right_data,
    output logic [plist_pkg::DATA_W-1:0]    data,
    output logic [plist_pkg::DATA_W-1:0]    sel_data
);
    import plist_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (idx == cmd.pos_idx);
    assign above = (idx > cmd.pos_idx);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.en && cmd.ins)
        begin
            if (hit)
                data_next = cmd.value;
            else if (above)
                data_next = left_data;
        end
        else if (cmd.en && cmd.del && (hit || above))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Only the addressed cell contributes to the read OR tree.
    assign sel_data = (cmd.en && cmd.rd && hit) ? data_reg : '0;

endmodule

FILE: hdl/positional_list_engine_unit.sv
`timescale 1ns / 1ps

// Positional list engine: an ordered list of up to CAPACITY 32-bit values,
// addressed by 1-based position and kept in a row of shifting cells.
// The req channel carries one request (func, position, value); the rsp
// channel returns one result (status, read_value, length) per request.
// Both are valid/ready channels; a transfer happens when both are high.
// A request is taken only while the engine is idle. The cycle after the
// transfer all cells shift or load in parallel and sixteen-cell partial
// reads are registered; the fold step then ORs them into the result register
// once the output register is free, and the engine returns to idle as it
// loads the result, so it takes no new request before the last one is through.
// The read path behind the cell row is a two-level registered OR tree.
// A result that the receiver stalls stays in the output register; the
// engine still accepts the next request and holds it in its fold step
// until the pending result transfers.
// Reset clears the element count and the handshake state; cell contents
// are not cleared, and only positions below the count are ever read.
module positional_list_engine_unit (
    input  logic  clk,
    input  logic  rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);
    import plist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_REDUCE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    plist_cmd_t        cmd_reg;
    plist_cmd_t        cmd_next;
    logic              status_reg;
    logic              status_next;
    plist_cmd_t        cell_cmd;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] sel_data  [CAPACITY];
    logic [DATA_W-1:0] group_or  [NGROUPS];
    logic [DATA_W-1:0] part_reg  [NGROUPS];
    logic [DATA_W-1:0] fold;

    logic              rsp_valid_reg;
    logic              rsp_status_reg;
    logic [DATA_W-1:0] rsp_value_reg;
    logic [LEN_W-1:0]  rsp_length_reg;

    logic              req_fire;
    logic              rsp_free;
    logic [POS_W:0]    cnt_ext;
    logic [POS_W:0]    pos_ext;
    logic              pos_nz;
    logic              get_ok;
    logic              ins_ok;
    logic              not_full;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // Request decode against the current element count.
    assign cnt_ext  = (POS_W+1)'(count_reg);
    assign pos_ext  = {1'b0, req.position};
    assign pos_nz   = (req.position != '0);
    assign not_full = (count_reg < CNT_W'(CAPACITY));
    assign get_ok   = pos_nz && (pos_ext <= cnt_ext);
    assign ins_ok   = not_full && pos_nz && (pos_ext <= cnt_ext + (POS_W+1)'(1));

    always_comb
    begin
        cmd_next         = '0;
        cmd_next.en      = 1'b1;
        cmd_next.pos_idx = req.position - POS_W'(1);
        cmd_next.value   = req.value;
        status_next      = 1'b1;
        unique case (req.func) inside
            FN_GET:
            begin
                cmd_next.rd = get_ok;
                status_next = !get_ok;
            end
            FN_INSERT:
            begin
                cmd_next.ins = ins_ok;
                status_next  = !ins_ok;
            end
            FN_DELETE:
            begin
                cmd_next.del = get_ok;
                cmd_next.rd  = get_ok;
                status_next  = !get_ok;
            end
            FN_CLEAR, FN_LENGTH:
            begin
                status_next = 1'b0;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
        end
    end

    // Clear is a count change only; it is flagged by func code in cmd-free form.
    logic clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= 1'b0;
        else if (req_fire)
            clr_reg <= (req.func == FN_CLEAR);
    end

    always_comb
    begin
        cell_cmd    = cmd_reg;
        cell_cmd.en = (state_reg == S_EXEC);
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (i == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[i+1];
            end
            plist_cell u_cell (
                .clk        (clk),
                .cmd        (cell_cmd),
                .idx        (POS_W'(i)),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i]),
                .sel_data   (sel_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_or[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < CAPACITY)
                    group_or[g] = group_or[g] | sel_data[g * GROUP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            for (int g = 0; g < NGROUPS; g++)
                part_reg[g] <= group_or[g];
        end
    end

    always_comb
    begin
        fold = '0;
        for (int g = 0; g < NGROUPS; g++)
            fold = fold | part_reg[g];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (clr_reg)
                    count_next = '0;
                else if (cmd_reg.ins)
                    count_next = count_reg + CNT_W'(1);
                else if (cmd_reg.del)
                    count_next = count_reg - CNT_W'(1);
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_REDUCE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REDUCE && rsp_free)
        begin
            rsp_status_reg <= status_reg;
            rsp_value_reg  <= fold;
            rsp_length_reg <= LEN_W'(count_reg);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.length     = rsp_length_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execute step");

    a_rsp_from_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_REDUCE))
        else $error("result appeared without a fold step");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && status_reg) |=> $stable(count_reg))
        else $error("failed request changed the element count");
`endif

endmodule

FILE: test/tb_positional_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_positional_list_engine_unit;
    import plist_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_CYCLES = 150;

    // Function codes that the engine does not define.
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam int MODE_MIXED = 0;
    localparam int MODE_GROW = 1;
    localparam int MODE_SHRINK = 2;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } list_request_t;

    typedef struct {
        logic              status;
        logic [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n;

    plist_req_if req();
    plist_rsp_if rsp();

    positional_list_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #4 clk = ~clk;

    list_request_t pending_reqs[$];
    list_result_t  awaited_results[$];

    // Expected list contents, updated as requests transfer.
    logic [DATA_W-1:0] list_cells[CAPACITY];
    int list_len = 0;
    int peak_len = 0;
    int error_results = 0;

    // Element count as the stimulus generator sees it, used to aim positions.
    int gen_len = 0;
    int n_queued = 0;

    int n_sent = 0;
    int n_checked = 0;
    int failures = 0;
    int hold_count = 0;
    int cycle_count = 0;

    int send_gap;
    int stall_left;
    int hold_left;
    int next_hold_at;

    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Mostly a position inside 1..span, sometimes just past it, an edge or anything.
    function automatic int pick_position(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return (span >= 1) ? $urandom_range(1, span) : 0;
        else if (r < 92)
            return $urandom_range(0, 1023);
        else if (r < 96)
            return span + 1;
        case ($urandom_range(0, 2))
            0: return 0;
            1: return span;
            default: return 1023;
        endcase
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] f, input int p,
                                 input logic [DATA_W-1:0] v);
        list_request_t item;
        item.func = f;
        item.position = POS_W'(p);
        item.value = v;
        pending_reqs.push_back(item);
        n_queued++;
        case (f)
            FN_INSERT:
                if (gen_len < CAPACITY && p >= 1 && p <= gen_len + 1)
                    gen_len++;
            FN_DELETE:
                if (p >= 1 && p <= gen_len)
                    gen_len--;
            FN_CLEAR:
                gen_len = 0;
            default: ;
        endcase
    endtask

    task automatic queue_random(input int mode);
        int r;
        int w_get;
        int w_ins;
        int w_del;
        int w_clr;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
            begin
                w_get = 20;
                w_ins = 60;
                w_del = 12;
                w_clr = 0;
            end
            MODE_SHRINK:
            begin
                w_get = 20;
                w_ins = 12;
                w_del = 60;
                w_clr = 0;
            end
            default:
            begin
                w_get = 30;
                w_ins = 30;
                w_del = 30;
                w_clr = 2;
            end
        endcase
        if (r < w_get)
            queue_request(FN_GET, pick_position(gen_len), pick_value());
        else if (r < w_get + w_ins)
            queue_request(FN_INSERT, pick_position(gen_len + 1), pick_value());
        else if (r < w_get + w_ins + w_del)
            queue_request(FN_DELETE, pick_position(gen_len), pick_value());
        else if (r < w_get + w_ins + w_del + w_clr)
            queue_request(FN_CLEAR, pick_position(gen_len), pick_value());
        else if (r < 97)
            queue_request(FN_LENGTH, pick_position(gen_len), pick_value());
        else
            queue_request(FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)),
                          $urandom_range(0, 1023), pick_value());
    endtask

    // Applies one transferred request to the expected list and records its result.
    function automatic void apply_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                          logic [DATA_W-1:0] v);
        list_result_t res;
        int pos;
        int k;
        pos = int'(p);
        res.status = ST_ERR;
        res.read_value = '0;
        case (f)
            FN_GET:
                if (pos >= 1 && pos <= list_len)
                begin
                    res.read_value = list_cells[pos - 1];
                    res.status = ST_OK;
                end
            FN_INSERT:
                if (list_len < CAPACITY && pos >= 1 && pos <= list_len + 1)
                begin
                    for (k = list_len; k > pos - 1; k--)
                        list_cells[k] = list_cells[k - 1];
                    list_cells[pos - 1] = v;
                    list_len++;
                    res.status = ST_OK;
                end
            FN_DELETE:
                if (pos >= 1 && pos <= list_len)
                begin
                    res.read_value = list_cells[pos - 1];
                    for (k = pos - 1; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k + 1];
                    list_len--;
                    res.status = ST_OK;
                end
            FN_CLEAR:
            begin
                list_len = 0;
                res.status = ST_OK;
            end
            FN_LENGTH:
                res.status = ST_OK;
            default: ;
        endcase
        res.length = LEN_W'(list_len);
        if (list_len > peak_len)
            peak_len = list_len;
        if (res.status == ST_ERR)
            error_results++;
        awaited_results.push_back(res);
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        list_request_t item;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.func <= FN_LENGTH;
            req.position <= '0;
            req.value <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                apply_request(req.func, req.position, req.value);
                n_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    item = pending_reqs.pop_front();
                    req.func <= item.func;
                    req.position <= item.position;
                    req.value <= item.value;
                    req.valid <= 1'b1;
                    // Every fourth stretch of 128 transfers runs back to back.
                    send_gap <= (((n_sent / 128) % 4) == 2) ? 0 : draw_idle();
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            next_hold_at <= 300;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with no request outstanding:", $time);
                    $display("    status %b value %h len %0d",
                             rsp.status, rsp.read_value, rsp.length);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %b, actual %b",
                                 $time, want.status, rsp.status);
                        failures++;
                    end
                    if (rsp.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.read_value, rsp.read_value);
                        failures++;
                    end
                    if (rsp.length !== want.length)
                    begin
                        $display("%0t: length mismatch, expected %0d, actual %0d",
                                 $time, want.length, rsp.length);
                        failures++;
                    end
                end
                n_checked++;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (n_checked >= next_hold_at)
            begin
                // Long hold-off so that the engine backs up into the request side.
                hold_left <= HOLD_CYCLES;
                next_hold_at <= next_hold_at + 500;
                hold_count++;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (((n_checked / 128) % 4) != 3 && $urandom_range(0, 99) < 25)
            begin
                stall_left <= draw_idle();
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int mode;
        rst_n = 1'b0;

        // Empty list: every positional access must fail.
        queue_request(FN_LENGTH, 0, 32'h0);
        queue_request(FN_GET, 1, 32'h0);
        queue_request(FN_DELETE, 1, 32'h0);
        queue_request(FN_INSERT, 0, 32'h1234_5678);
        queue_request(FN_INSERT, 2, 32'h1234_5678);
        // Build at the front, the end and the middle with extreme values.
        queue_request(FN_INSERT, 1, 32'h8000_0000);
        queue_request(FN_INSERT, 2, 32'h7FFF_FFFF);
        queue_request(FN_INSERT, 1, 32'hFFFF_FFFF);
        queue_request(FN_INSERT, 2, 32'h0000_0000);
        queue_request(FN_GET, 1, 32'h0);
        queue_request(FN_GET, 4, 32'h0);
        queue_request(FN_GET, 5, 32'h0);
        queue_request(FN_GET, 0, 32'h0);
        queue_request(FN_GET, 1023, 32'hFFFF_FFFF);
        queue_request(FN_DELETE, 4, 32'h0);
        queue_request(FN_DELETE, 1, 32'h0);
        queue_request(FN_DELETE, 0, 32'h0);
        queue_request(FN_DELETE, 1023, 32'h0);
        queue_request(FN_SPARE_FIRST, 1, 32'h0);
        queue_request(FN_SPARE_MID, 1023, 32'hFFFF_FFFF);
        queue_request(FN_SPARE_LAST, 2, 32'h0);
        queue_request(FN_CLEAR, 0, 32'h0);
        queue_request(FN_LENGTH, 1023, 32'h0);
        queue_request(FN_GET, 1, 32'h0);

        // Fill the list to capacity, then probe it while full.
        while (gen_len < CAPACITY)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_request(FN_GET, pick_position(gen_len), pick_value());
            else
                queue_request(FN_INSERT, pick_position(gen_len + 1), pick_value());
        end
        queue_request(FN_INSERT, 1, pick_value());
        queue_request(FN_INSERT, CAPACITY, pick_value());
        queue_request(FN_INSERT, CAPACITY + 1, pick_value());
        queue_request(FN_GET, CAPACITY, 32'h0);
        queue_request(FN_GET, CAPACITY + 1, 32'h0);
        queue_request(FN_DELETE, CAPACITY, 32'h0);
        queue_request(FN_INSERT, CAPACITY, pick_value());
        queue_request(FN_LENGTH, 0, 32'h0);

        while (n_queued < RANDOM_ITEMS + 24)
        begin
            mode = $urandom_range(MODE_MIXED, MODE_SHRINK);
            repeat (150)
                queue_random(mode);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || req.valid || awaited_results.size() > 0)
            @(negedge clk);
        // Keep running to catch any result that should not be there.
        repeat (20) @(negedge clk);

        $display("Sent %0d requests, checked %0d results", n_sent, n_checked);
        $display("(%0d error results, peak length %0d).", error_results, peak_len);
        $display("Receiver held off %0d times; %0d field mismatches or stray results.",
                 hold_count, failures);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
